// ===== rtl/ten_bit_word_payload_packer_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Ten-bit word payload packer: assertion macros
// Shared property shorthands for the packer's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef TEN_BIT_WORD_PAYLOAD_PACKER_UNIT_MACROS_SVH
`define TEN_BIT_WORD_PAYLOAD_PACKER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBWPP_ASSERT_SAME(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("packer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TBWPP_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("packer: next-cycle check failed");

`endif

// ===== rtl/tbwpp_pkg.sv =====
// ---------------------------------------------------------------------------
// Ten-bit word payload packer: package
// Result word layout, operation and register codes, reset values.
// ---------------------------------------------------------------------------
package tbwpp_pkg;

	// Operation codes of an input word.
	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Configuration register indexes.
	localparam logic REG_HD_MODE       = 1'b0;
	localparam logic REG_PAYLOAD_BYTES = 1'b1;

	// Reset value of the payload size register.
	localparam logic [10:0] PAYLOAD_BYTES_RST = 11'd1376;

	// One result word.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        byte_valid;
		logic [10:0] byte_index;
		logic [15:0] sequence_res;
		logic [31:0] timestamp;
		logic [7:0]  frame_number;
		logic        frame_close;
		logic [10:0] zero_fill;
		logic        last;
	} res_t;

	// Results of one processed input word, handed to the result queue.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

// ===== rtl/ten_bit_word_payload_packer_unit.sv =====
// ---------------------------------------------------------------------------
// Ten-bit word payload packer
// Packs ten-bit video words MSB-first into payload bytes of fixed-size
// packets and reports packet sequence, timestamp and frame on every byte.
// ---------------------------------------------------------------------------
// Channel   Handshake              Payload
// item      item_valid/item_stall  operation, word
// res       res_valid/res_stall    data_byte ... last (one or two results per word)
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
//
// An input word is registered, packed in one pass and its one or two results
// enter a two-entry queue; the port shows the head of the queue, so a result
// appears there once the queue has registered it.
// One input word is taken per cycle while the result side keeps pace; the
// output port moves one result per cycle while res_stall is low, so six held
// bits or a flush with a partial byte, which give two results, slow the input.
// Reset clears all packet state; the payload size returns to 1376 bytes.
// ---------------------------------------------------------------------------
`include "ten_bit_word_payload_packer_unit_macros.svh"

module ten_bit_word_payload_packer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        operation,
	input  logic [9:0]  word,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  data_byte,
	output logic        byte_valid,
	output logic [10:0] byte_index,
	output logic [15:0] sequence_res,
	output logic [31:0] timestamp,
	output logic [7:0]  frame_number,
	output logic        frame_close,
	output logic [10:0] zero_fill,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);

	logic              hd_mode_q;
	logic [10:0]       payload_bytes_q;
	logic [1:0]        free;
	tbwpp_pkg::push_t  push;
	tbwpp_pkg::res_t   head;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_mode_q       <= 1'b0;
			payload_bytes_q <= tbwpp_pkg::PAYLOAD_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tbwpp_pkg::REG_HD_MODE:       hd_mode_q       <= cfg_data[0];
				tbwpp_pkg::REG_PAYLOAD_BYTES: payload_bytes_q <= cfg_data;
				default:                      hd_mode_q       <= hd_mode_q;
			endcase
		end
	end

	tbwpp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.operation     (operation),
		.word          (word),
		.hd_mode       (hd_mode_q),
		.payload_bytes (payload_bytes_q),
		.free          (free),
		.push          (push)
	);

	tbwpp_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.free      (free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.head      (head)
	);

	// Result word fields.
	assign data_byte    = head.data_byte;
	assign byte_valid   = head.byte_valid;
	assign byte_index   = head.byte_index;
	assign sequence_res = head.sequence_res;
	assign timestamp    = head.timestamp;
	assign frame_number = head.frame_number;
	assign frame_close  = head.frame_close;
	assign zero_fill    = head.zero_fill;
	assign last         = head.last;

	// A close result always ends its item's results.
	`TBWPP_ASSERT_SAME(a_close_is_last, clk, arst_n, res_valid && frame_close, last)
	// Non-byte results are close results only.
	`TBWPP_ASSERT_SAME(a_nonbyte_closes, clk, arst_n, res_valid && !byte_valid, frame_close)
	// Byte results carry no padding count.
	`TBWPP_ASSERT_SAME(a_byte_no_fill, clk, arst_n, res_valid && byte_valid, zero_fill == '0)
	// Both results of an item are queued together, so the second follows at once.
	`TBWPP_ASSERT_NEXT(a_pair_follows, clk, arst_n, res_valid && !res_stall && !last, res_valid)

endmodule

// ===== rtl/tbwpp_core.sv =====
// ---------------------------------------------------------------------------
// Ten-bit word payload packer: packing core
// Input register, packet state and the single-pass packing logic.
// ---------------------------------------------------------------------------
module tbwpp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 operation,
	input  logic [9:0]           word,
	input  logic                 hd_mode,
	input  logic [10:0]          payload_bytes,
	input  logic [1:0]           free,
	output tbwpp_pkg::push_t     push
);

	// Packet bookkeeping that a new byte may advance.
	typedef struct packed {
		logic [10:0] wi;
		logic [15:0] seq;
		logic [31:0] stamp;
	} pkt_t;

	// Opens a new packet when the current one is full, and latches the
	// timestamp when a byte is the first of its packet.
	function automatic pkt_t start_byte(pkt_t p, logic [10:0] size, logic [31:0] now);
		pkt_t r;
		r = p;
		if (r.wi >= size) begin
			r.seq = r.seq + 16'd1;
			r.wi  = '0;
		end
		if (r.wi == '0) begin
			r.stamp = now;
		end
		return r;
	endfunction

	logic        valid_s1;
	logic        op_s1;
	logic [9:0]  word_s1;

	logic [1:0]  phase_q;
	logic [5:0]  pend_q;
	logic [10:0] wi_q;
	logic [15:0] seq_q;
	logic [31:0] wc_q;
	logic [29:0] hdq_q;
	logic [3:0]  hdr_q;
	logic [7:0]  frame_q;
	logic [31:0] stamp_q;

	logic        accept;
	logic        adv;
	logic [1:0]  need;
	logic [10:0] size;
	logic [31:0] now;
	pkt_t        p0;
	pkt_t        p1;
	pkt_t        p2;
	pkt_t        p3;
	pkt_t        pn;
	logic [7:0]  byte0;
	logic [5:0]  pend_n;
	logic [10:0] wi1;
	logic [4:0]  hdr_sum;
	tbwpp_pkg::res_t r0;
	tbwpp_pkg::res_t r1;

	// A zero payload size counts as one byte.
	assign size = (payload_bytes == '0) ? 11'd1 : payload_bytes;
	assign now  = hd_mode ? {2'b00, hdq_q} : wc_q;
	assign hdr_sum = {1'b0, hdr_q} + 5'd2;

	// Number of result words the held item produces.
	always_comb begin
		if (op_s1 == tbwpp_pkg::OP_PUSH) begin
			need = (phase_q == 2'd3) ? 2'd2 : 2'd1;
		end else begin
			need = (phase_q != 2'd0) ? 2'd2 : 2'd1;
		end
	end

	assign adv        = valid_s1 && (need <= free);
	assign item_stall = valid_s1 && !adv;
	assign accept     = item_valid && !item_stall;

	// Packing logic: up to two results and the next packet state.
	always_comb begin
		p0 = '{wi: wi_q, seq: seq_q, stamp: stamp_q};
		p1 = p0;
		p2 = p0;
		p3 = p0;
		pn = p0;
		byte0  = '0;
		pend_n = '0;
		wi1    = wi_q;
		r0 = '0;
		r1 = '0;
		if (op_s1 == tbwpp_pkg::OP_PUSH) begin
			// Leading byte from the held bits and the top of the new word.
			unique case (phase_q)
				2'd0: begin
					byte0  = word_s1[9:2];
					pend_n = {4'b0000, word_s1[1:0]};
				end
				2'd1: begin
					byte0  = {pend_q[1:0], word_s1[9:4]};
					pend_n = {2'b00, word_s1[3:0]};
				end
				2'd2: begin
					byte0  = {pend_q[3:0], word_s1[9:6]};
					pend_n = word_s1[5:0];
				end
				2'd3: begin
					byte0  = {pend_q[5:0], word_s1[9:8]};
					pend_n = '0;
				end
				default: begin
					byte0  = '0;
					pend_n = '0;
				end
			endcase
			p1 = (phase_q == 2'd0) ? start_byte(p0, size, now) : p0;
			p2 = p1;
			p2.wi = p1.wi + 11'd1;
			p3 = start_byte(p2, size, now);
			pn = p3;
			r0.data_byte    = byte0;
			r0.byte_valid   = 1'b1;
			r0.byte_index   = p1.wi;
			r0.sequence_res = p1.seq;
			r0.timestamp    = p1.stamp;
			r0.frame_number = frame_q;
			r0.last         = (phase_q != 2'd3);
			// A full word completes a second byte when six bits were held.
			r1.data_byte    = word_s1[7:0];
			r1.byte_valid   = 1'b1;
			r1.byte_index   = p3.wi;
			r1.sequence_res = p3.seq;
			r1.timestamp    = p3.stamp;
			r1.frame_number = frame_q;
			r1.last         = 1'b1;
			if (phase_q == 2'd3) begin
				pn.wi = p3.wi + 11'd1;
			end
		end else begin
			// Flush the partial byte, low bits zero, then close the packet.
			unique case (phase_q)
				2'd1:    byte0 = {pend_q[1:0], 6'b000000};
				2'd2:    byte0 = {pend_q[3:0], 4'b0000};
				2'd3:    byte0 = {pend_q[5:0], 2'b00};
				default: byte0 = '0;
			endcase
			wi1 = (phase_q != 2'd0) ? wi_q + 11'd1 : wi_q;
			r0.data_byte    = byte0;
			r0.byte_valid   = 1'b1;
			r0.byte_index   = wi_q;
			r0.sequence_res = seq_q;
			r0.timestamp    = stamp_q;
			r0.frame_number = frame_q;
			r1.sequence_res = seq_q;
			r1.timestamp    = (wi1 == '0) ? now : stamp_q;
			r1.frame_number = frame_q;
			r1.frame_close  = 1'b1;
			r1.zero_fill    = (size > wi1) ? size - wi1 : '0;
			r1.last         = 1'b1;
			pn.wi  = '0;
			pn.seq = seq_q + 16'd1;
		end
	end

	// Results in queue order; a lone close result takes the first slot.
	always_comb begin
		push.cnt = need;
		if (op_s1 == tbwpp_pkg::OP_FLUSH && phase_q == 2'd0) begin
			push.r0 = r1;
		end else begin
			push.r0 = r0;
		end
		push.r1 = r1;
		if (!adv) begin
			push.cnt = 2'd0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			word_s1 <= word;
		end
	end

	// Input register valid and packet state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= '0;
			pend_q   <= '0;
			wi_q     <= '0;
			seq_q    <= '0;
			wc_q     <= '0;
			hdq_q    <= '0;
			hdr_q    <= '0;
			frame_q  <= '0;
			stamp_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				wi_q    <= pn.wi;
				seq_q   <= pn.seq;
				stamp_q <= pn.stamp;
				if (op_s1 == tbwpp_pkg::OP_PUSH) begin
					phase_q <= phase_q + 2'd1;
					pend_q  <= pend_n;
					wc_q    <= wc_q + 32'd1;
					// Track floor(2 * count / 11) as quotient and remainder.
					if (wc_q == '1) begin
						hdq_q <= '0;
						hdr_q <= '0;
					end else if (hdr_sum >= 5'd11) begin
						hdq_q <= hdq_q + 30'd1;
						hdr_q <= 4'(hdr_sum - 5'd11);
					end else begin
						hdr_q <= hdr_sum[3:0];
					end
				end else begin
					phase_q <= '0;
					pend_q  <= '0;
					frame_q <= frame_q + 8'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/tbwpp_resq.sv =====
// ---------------------------------------------------------------------------
// Ten-bit word payload packer: result queue
// Two-entry output queue that takes one or two results a cycle while it has room.
// ---------------------------------------------------------------------------
module tbwpp_resq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tbwpp_pkg::push_t     push,
	output logic [1:0]           free,
	output logic                 res_valid,
	input  logic                 res_stall,
	output tbwpp_pkg::res_t      head
);

	tbwpp_pkg::res_t ent_q [2];
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;
	logic       wr_ptr;

	assign res_valid = (count_q != '0);
	assign pop       = res_valid && !res_stall;
	assign head      = ent_q[rd_ptr_q];
	assign wr_ptr    = rd_ptr_q ^ count_q[0];

	// Space after this cycle's pop.
	always_comb begin
		unique case (count_q)
			2'd0:    free = 2'd2;
			2'd1:    free = pop ? 2'd2 : 2'd1;
			default: free = pop ? 2'd1 : 2'd0;
		endcase
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.cnt != '0) begin
			ent_q[wr_ptr] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			ent_q[!wr_ptr] <= push.r1;
		end
	end

	// Read pointer and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_q ^ pop;
			count_q  <= count_q - {1'b0, pop} + push.cnt;
		end
	end

endmodule

// ===== bench/ten_bit_word_payload_packer_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ten-bit word payload packer: self-checking test
// Drives pushed video words and frame ends into the packer while both
// channels idle at random, packs the same words in a behavioural model of
// the payload and compares every result word field by field, in order.
// ---------------------------------------------------------------------------
module ten_bit_word_payload_packer_unit_test;

	localparam int WATCHDOG_LIMIT = 4000;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic        operation;
	logic [9:0]  word;
	logic        res_valid;
	logic        res_stall;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic [10:0] byte_index;
	logic [15:0] sequence_res;
	logic [31:0] timestamp;
	logic [7:0]  frame_number;
	logic        frame_close;
	logic [10:0] zero_fill;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [10:0] cfg_data;

	ten_bit_word_payload_packer_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.word         (word),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.byte_index   (byte_index),
		.sequence_res (sequence_res),
		.timestamp    (timestamp),
		.frame_number (frame_number),
		.frame_close  (frame_close),
		.zero_fill    (zero_fill),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Model of the packer: register copies and packing state.
	logic        hd_sel      = 1'b0;
	logic [10:0] size_sel    = tbwpp_pkg::PAYLOAD_BYTES_RST;
	logic [1:0]  held_pairs  = '0;
	logic [7:0]  carry_bits  = '0;
	logic [10:0] byte_pos    = '0;
	logic [15:0] pkt_seq     = '0;
	logic [31:0] words_seen  = '0;
	logic [7:0]  frame_no    = '0;
	logic [31:0] pkt_stamp   = '0;

	// Predicted result words, oldest first.
	tbwpp_pkg::res_t packed_q[$];
	tbwpp_pkg::res_t head;

	bit idling = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;
	int errors = 0;
	int n_pushes = 0;
	int n_flushes = 0;
	int n_results = 0;
	int n_settings = 0;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Timestamp that a packet opened now would latch.
	function automatic logic [31:0] stamp_of_count();
		logic [63:0] prod;
		prod = {32'd0, words_seen} * 64'd2;
		prod = prod / 64'd11;
		return hd_sel ? prod[31:0] : words_seen;
	endfunction

	function automatic logic [10:0] packet_size();
		return (size_sel == 11'd0) ? 11'd1 : size_sel;
	endfunction

	// A new byte either rolls over to the next packet or opens the first one.
	function automatic void open_byte();
		if (byte_pos >= packet_size()) begin
			pkt_seq  = pkt_seq + 16'd1;
			byte_pos = '0;
		end
		if (byte_pos == 11'd0)
			pkt_stamp = stamp_of_count();
	endfunction

	function automatic void emit_byte(input logic [7:0] value);
		tbwpp_pkg::res_t r;
		r              = '0;
		r.data_byte    = value;
		r.byte_valid   = 1'b1;
		r.byte_index   = byte_pos;
		r.sequence_res = pkt_seq;
		r.timestamp    = pkt_stamp;
		r.frame_number = frame_no;
		packed_q.push_back(r);
		byte_pos = byte_pos + 11'd1;
	endfunction

	// Packs one accepted word and queues the result words that it causes.
	function automatic void pack_item(input logic op, input logic [9:0] value);
		logic [15:0]     acc;
		logic [15:0]     tmp;
		logic [10:0]     sz;
		int              nb;
		tbwpp_pkg::res_t r;
		if (op == tbwpp_pkg::OP_PUSH) begin
			acc = {carry_bits[5:0], value};
			nb  = held_pairs * 2 + 10;
			if (held_pairs == 2'd0)
				open_byte();
			while (nb >= 8) begin
				nb  = nb - 8;
				tmp = acc >> nb;
				emit_byte(tmp[7:0]);
				if (nb > 0)
					open_byte();
			end
			tmp        = acc & ((16'd1 << nb) - 16'd1);
			carry_bits = tmp[7:0];
			held_pairs = 2'(nb / 2);
			words_seen = words_seen + 32'd1;
		end else begin
			// Flush the partial byte with zero low bits, then close the packet.
			if (held_pairs != 2'd0) begin
				tmp = {10'd0, carry_bits[5:0]} << (8 - held_pairs * 2);
				emit_byte(tmp[7:0]);
			end
			sz             = packet_size();
			r              = '0;
			r.sequence_res = pkt_seq;
			r.timestamp    = (byte_pos == 11'd0) ? stamp_of_count() : pkt_stamp;
			r.frame_number = frame_no;
			r.frame_close  = 1'b1;
			r.zero_fill    = (sz > byte_pos) ? sz - byte_pos : 11'd0;
			packed_q.push_back(r);
			pkt_seq    = pkt_seq + 16'd1;
			byte_pos   = '0;
			held_pairs = '0;
			carry_bits = '0;
			frame_no   = frame_no + 8'd1;
		end
		r      = packed_q.pop_back();
		r.last = 1'b1;
		packed_q.push_back(r);
	endfunction

	function automatic void compare_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
			errors++;
		end
	endfunction

	// Result side: random stall bursts while idling is on.
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!idling || !arst_n)
				stall_left = 0;
			else if (stall_left > 0)
				stall_left--;
			else if ($urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 7);
			res_stall <= (stall_left != 0);
		end
	end

	// Each accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (packed_q.size() == 0) begin
				$display("%0t: result word with none expected, data_byte 0x%0h close %0b",
					$time, data_byte, frame_close);
				errors++;
			end else begin
				head = packed_q.pop_front();
				n_results++;
				compare_field("data_byte", 32'(head.data_byte), 32'(data_byte));
				compare_field("byte_valid", 32'(head.byte_valid), 32'(byte_valid));
				compare_field("byte_index", 32'(head.byte_index), 32'(byte_index));
				compare_field("sequence_res", 32'(head.sequence_res), 32'(sequence_res));
				compare_field("timestamp", head.timestamp, timestamp);
				compare_field("frame_number", 32'(head.frame_number), 32'(frame_number));
				compare_field("frame_close", 32'(head.frame_close), 32'(frame_close));
				compare_field("zero_fill", 32'(head.zero_fill), 32'(zero_fill));
				compare_field("last", 32'(head.last), 32'(last));
			end
		end
	end

	// Watchdog: ends the run when no handshake completes for too long.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d result words outstanding",
				$time, WATCHDOG_LIMIT, packed_q.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one word, with an optional gap first, and waits for acceptance.
	task automatic send_word(input logic op, input logic [9:0] value);
		if (idling && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation  <= op;
		word       <= value;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		pack_item(op, value);
		if (op == tbwpp_pkg::OP_PUSH)
			n_pushes++;
		else
			n_flushes++;
	endtask

	// Stops offering words and waits for every predicted result word.
	task automatic drain();
		item_valid <= 1'b0;
		while (packed_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes both registers while the packer is idle.
	task automatic set_config(input logic hd, input logic [10:0] size);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= tbwpp_pkg::REG_HD_MODE;
		cfg_data  <= {10'd0, hd};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		hd_sel = hd;
		cfg_index <= tbwpp_pkg::REG_PAYLOAD_BYTES;
		cfg_data  <= size;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		size_sel = size;
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// Frame ends straight after reset close empty packets.
	task automatic test_empty_frames();
		send_word(tbwpp_pkg::OP_FLUSH, 10'h3FF);
		send_word(tbwpp_pkg::OP_FLUSH, 10'h000);
	endtask

	// Extreme and alternating words, then a flush of the partial byte.
	task automatic test_word_extremes();
		send_word(tbwpp_pkg::OP_PUSH, 10'h000);
		send_word(tbwpp_pkg::OP_PUSH, 10'h3FF);
		send_word(tbwpp_pkg::OP_PUSH, 10'h2AA);
		send_word(tbwpp_pkg::OP_PUSH, 10'h155);
		send_word(tbwpp_pkg::OP_PUSH, 10'h200);
		send_word(tbwpp_pkg::OP_FLUSH, 10'h155);
	endtask

	// Two-byte packets roll over lazily as bytes start.
	task automatic test_packet_rollover();
		set_config(1'b0, 11'd2);
		send_word(tbwpp_pkg::OP_PUSH, 10'h3C3);
		send_word(tbwpp_pkg::OP_PUSH, 10'h0F0);
		send_word(tbwpp_pkg::OP_PUSH, 10'h001);
		send_word(tbwpp_pkg::OP_PUSH, 10'h3FE);
		send_word(tbwpp_pkg::OP_FLUSH, 10'h000);
	endtask

	// A payload size of zero behaves as one byte, as does a size of one.
	task automatic test_tiny_payload();
		set_config(1'b0, 11'd0);
		send_word(tbwpp_pkg::OP_PUSH, 10'h2F1);
		send_word(tbwpp_pkg::OP_PUSH, 10'h10E);
		set_config(1'b0, 11'd1);
		send_word(tbwpp_pkg::OP_PUSH, 10'h3A5);
		send_word(tbwpp_pkg::OP_FLUSH, 10'h3FF);
	endtask

	// Lowering the size below the fill level saturates the zero fill.
	task automatic test_size_lowered();
		set_config(1'b0, 11'd2047);
		send_word(tbwpp_pkg::OP_PUSH, 10'h1FF);
		send_word(tbwpp_pkg::OP_PUSH, 10'h201);
		send_word(tbwpp_pkg::OP_PUSH, 10'h3F0);
		set_config(1'b0, 11'd2);
		send_word(tbwpp_pkg::OP_FLUSH, 10'h000);
	endtask

	// HD timestamps scale the word count by two elevenths.
	task automatic test_hd_timestamp();
		set_config(1'b1, 11'd4);
		send_word(tbwpp_pkg::OP_PUSH, 10'h0AB);
		send_word(tbwpp_pkg::OP_PUSH, 10'h354);
		send_word(tbwpp_pkg::OP_PUSH, 10'h3FF);
		send_word(tbwpp_pkg::OP_FLUSH, 10'h2AA);
	endtask

	// Frames of random words under one setting; calm turns idling off.
	task automatic test_random_frames(input logic hd, input logic [10:0] size,
			input int count, input bit calm);
		int i;
		int pick;
		set_config(hd, size);
		for (i = 0; i < count; i++) begin
			if (i % 35 == 0)
				idling = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 39);
			if (pick == 0) begin
				send_word(tbwpp_pkg::OP_FLUSH, 10'($urandom_range(0, 1023)));
				if ($urandom_range(0, 3) == 0)
					send_word(tbwpp_pkg::OP_FLUSH, 10'($urandom_range(0, 1023)));
			end else if (pick < 4) begin
				send_word(tbwpp_pkg::OP_PUSH, pick[0] ? 10'h3FF : 10'h000);
			end else begin
				send_word(tbwpp_pkg::OP_PUSH, 10'($urandom_range(0, 1023)));
			end
		end
	endtask

	// Test sequence.
	initial begin
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		operation  <= tbwpp_pkg::OP_PUSH;
		word       <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= tbwpp_pkg::REG_HD_MODE;
		cfg_data   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_frames();
		test_word_extremes();
		test_packet_rollover();
		test_tiny_payload();
		test_size_lowered();
		test_hd_timestamp();

		test_random_frames(1'b0, 11'd2047, 105, 1'b0);
		test_random_frames(1'b1, 11'd2, 105, 1'b0);
		test_random_frames(1'b0, 11'($urandom_range(2, 48)), 105, 1'b0);
		test_random_frames(1'b1, 11'($urandom_range(3, 200)), 105, 1'b0);
		test_random_frames(1'b1, 11'd1376, 105, 1'b0);
		test_random_frames(1'b0, 11'($urandom_range(2, 16)), 105, 1'b1);
		drain();

		if (packed_q.size() != 0) begin
			$display("%0t: %0d result words never arrived", $time, packed_q.size());
			errors++;
		end
		$display("Packed %0d words and %0d frame ends into %0d checked result words,",
			n_pushes, n_flushes, n_results);
		$display("across %0d register settings, with %0d mismatches.", n_settings, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
